// ----- rtl/bdq_pkg.sv -----
// ---------------------------------------------------------------------------
// bdq_pkg
// Item types, operation and status codes, and controller types shared by
// the deque block.
// ---------------------------------------------------------------------------
package bdq_pkg;

   localparam logic [2:0] FUNC_NONE       = 3'd0;
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd2;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [31:0] WORD_NONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic [10:0]        count;
      logic               is_empty;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic need_fill;
      logic rsp_free;
   } ctrl_status_type;

   typedef struct packed {
      logic accept_ready;
      logic fill;
      logic emit;
   } ctrl_type;

endpackage

// ----- rtl/bdq_ram.sv -----
// ---------------------------------------------------------------------------
// bdq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bdq_ctrl.sv -----
// ---------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for one item: accept, optional end-value refill from memory,
// then hand the result to the output register.
// ---------------------------------------------------------------------------
module bdq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  bdq_pkg::ctrl_status_type stat,
   output bdq_pkg::ctrl_type        ctrl
);

   bdq_pkg::state_type state_ff;
   bdq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.need_fill ? bdq_pkg::ST_FILL : bdq_pkg::ST_EMIT;
            end
         end
         bdq_pkg::ST_FILL: begin
            state_in = bdq_pkg::ST_EMIT;
         end
         bdq_pkg::ST_EMIT: begin
            if (stat.rsp_free) begin
               state_in = bdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.accept_ready = (state_ff == bdq_pkg::ST_IDLE);
      ctrl.fill         = (state_ff == bdq_pkg::ST_FILL);
      ctrl.emit         = (state_ff == bdq_pkg::ST_EMIT) && stat.rsp_free;
   end

endmodule

// ----- rtl/bounded_deque_unit.sv -----
// ---------------------------------------------------------------------------
// bounded_deque_unit
// Double-ended queue in a ring buffer memory with head pointer, count and
// registered front and back values.
// ---------------------------------------------------------------------------
// The result is registered from the emit state after the accepting edge, or
// after a fill state when a pop must refill the front or back value from memory.
// The sequencer accepts a new item only in the idle state, so none is taken
// until the last result enters the output register; output stalls delay that.
// Reset clears the head pointer, count, output valid and controller; the ring
// memory is not cleared and no clearing pass runs.
module bounded_deque_unit #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bdq_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;
   localparam int KW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

   bdq_pkg::ctrl_status_type stat;
   bdq_pkg::ctrl_type        ctrl;

   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic                  fill_front_ff, fill_front_in;
   logic [31:0]           popped_ff, popped_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type      rsp_ff, rsp_in;

   logic                  fire;
   logic                  need_fill;
   logic [DATA_WIDTH-1:0] push_data;
   logic [IW-1:0]         head_dec, head_inc;
   logic [SW-1:0]         sum_tail, sum_prev;
   logic [IW-1:0]         tail_slot, prev_slot;
   logic                  wr_en, rd_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  is_empty;
   logic                  is_full;

   assign fire      = req_valid && ctrl.accept_ready;
   assign req_stall = !ctrl.accept_ready;
   assign push_data = DATA_WIDTH'(req_data.value[KW-1:0]);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == FULL_CNT);

   assign head_dec  = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign sum_tail  = SW'(head_ff) + SW'(count_ff);
   assign sum_prev  = SW'(head_ff) + SW'(count_ff) - SW'(2);
   assign tail_slot = (sum_tail >= DEPTH_S) ? IW'(sum_tail - DEPTH_S) : IW'(sum_tail);
   assign prev_slot = (sum_prev >= DEPTH_S) ? IW'(sum_prev - DEPTH_S) : IW'(sum_prev);

   assign stat = '{need_fill: need_fill, rsp_free: (!rsp_valid_ff || !rsp_stall)};

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      fill_front_in = fill_front_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      need_fill     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = tail_slot;
      rd_en         = 1'b0;
      rd_addr       = head_inc;
      if (fire) begin
         popped_in = bdq_pkg::WORD_NONE;
         status_in = bdq_pkg::STATUS_OK;
         priority if (req_data.func == bdq_pkg::FUNC_PUSH_FRONT ||
                      req_data.func == bdq_pkg::FUNC_PUSH_BACK) begin
            if (is_full) begin
               status_in = bdq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (req_data.func == bdq_pkg::FUNC_PUSH_FRONT) begin
                  head_in  = head_dec;
                  wr_addr  = head_dec;
                  front_in = push_data;
                  if (is_empty) begin
                     back_in = push_data;
                  end
               end else begin
                  back_in = push_data;
                  if (is_empty) begin
                     front_in = push_data;
                  end
               end
            end
         end else if (req_data.func == bdq_pkg::FUNC_POP_FRONT ||
                      req_data.func == bdq_pkg::FUNC_POP_BACK) begin
            if (is_empty) begin
               status_in = bdq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               if (req_data.func == bdq_pkg::FUNC_POP_FRONT) begin
                  popped_in     = 32'(front_ff[KW-1:0]);
                  head_in       = head_inc;
                  fill_front_in = 1'b1;
                  if (count_ff == CW'(2)) begin
                     front_in = back_ff;
                  end else if (count_ff > CW'(2)) begin
                     rd_en     = 1'b1;
                     rd_addr   = head_inc;
                     need_fill = 1'b1;
                  end
               end else begin
                  popped_in     = 32'(back_ff[KW-1:0]);
                  fill_front_in = 1'b0;
                  if (count_ff == CW'(2)) begin
                     back_in = front_ff;
                  end else if (count_ff > CW'(2)) begin
                     rd_en     = 1'b1;
                     rd_addr   = prev_slot;
                     need_fill = 1'b1;
                  end
               end
            end
         end else begin
            status_in = bdq_pkg::STATUS_OK;
         end
      end
      if (ctrl.fill) begin
         if (fill_front_ff) begin
            front_in = rd_data;
         end else begin
            back_in = rd_data;
         end
      end
   end

   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.popped_value = popped_ff;
         rsp_in.status       = status_ff;
         rsp_in.count        = 11'(count_ff);
         rsp_in.is_empty     = is_empty;
         rsp_in.front_value  = is_empty ? bdq_pkg::WORD_NONE : 32'(front_ff[KW-1:0]);
         rsp_in.back_value   = is_empty ? bdq_pkg::WORD_NONE : 32'(back_ff[KW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      fill_front_ff <= fill_front_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
